/* hdl/bsc_pkg.sv */
package bsc_pkg;

  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_CHAR = 2'd1,
    ST_BAD_LEN  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    JOB_ENC = 2'd0,
    JOB_DEC = 2'd1,
    JOB_ERR = 2'd2
  } job_kind_e;

  typedef enum logic [1:0] {
    ALPH_PLUS       = 2'd0,
    ALPH_UNDERSCORE = 2'd1,
    ALPH_HIGH       = 2'd2
  } alphabet_e;

  localparam logic CFG_DIRECTION = 1'b0;
  localparam logic CFG_ALPHABET  = 1'b1;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    status_e    status;
  } out_item_t;

  // Work handed from the front end to the back end: one group or one error
  typedef struct packed {
    job_kind_e   kind;
    logic [23:0] bits;
    logic [1:0]  final_idx;  // index of the last result of this job
    logic [1:0]  npad;       // pad characters at the end of an encoded group
    logic        last;
    status_e     status;
  } job_t;

  typedef struct packed {
    logic direction;
    logic clear;
  } front_cfg_t;

  typedef struct packed {
    logic       ok;
    logic       pad;
    logic [5:0] v;
  } dec_t;

  function automatic logic [7:0] enc_char(logic [5:0] v, logic [1:0] alph);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v - 6'd26};
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v - 6'd52};
    end else if (v == 6'd62) begin
      c = (alph == ALPH_UNDERSCORE) ? 8'h5F : (alph == ALPH_HIGH) ? 8'hF8 : 8'h2B;
    end else begin
      c = (alph == ALPH_UNDERSCORE) ? 8'h40 : (alph == ALPH_HIGH) ? 8'hFE : 8'h2F;
    end
    return c;
  endfunction

  function automatic logic [7:0] pad_char(logic [1:0] alph);
    return (alph == ALPH_HIGH) ? 8'h83 : 8'h3D;
  endfunction

  // Accept every alphabet at once; pads decode as zero
  function automatic dec_t dec_char(logic [7:0] c);
    dec_t r;
    r = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r.ok = 1'b1;
      r.v  = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r.ok = 1'b1;
      r.v  = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r.ok = 1'b1;
      r.v  = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B || c == 8'h5F || c == 8'hF8) begin
      r.ok = 1'b1;
      r.v  = 6'd62;
    end else if (c == 8'h2F || c == 8'h40 || c == 8'hFE) begin
      r.ok = 1'b1;
      r.v  = 6'd63;
    end else if (c == 8'h3D || c == 8'h83) begin
      r.ok  = 1'b1;
      r.pad = 1'b1;
    end
    return r;
  endfunction

endpackage

/* hdl/base64_stream_codec.sv */
// Streaming base64 codec, one byte or character per request in, one per request out.
// Register 0 picks the direction (0 encode, 1 decode) and clears any partial group;
// register 1 picks the 62/63/pad characters (0 '+' '/' '=', 1 '_' '@' '=', 2 F8 FE 83).
// The front end takes one request per clock while its job queue (QueueDepth groups) has
// room; the back end writes one result per clock into the output register while it is
// empty or being popped, so in encoding the single result port sets the rate at 4
// results per 3 bytes; decoding gives 3 results per 4 characters. A decode error gives
// one result with out_last set and drops input up to the next last flag.
module base64_stream_codec #(
  parameter int unsigned QueueDepth = bsc_pkg::QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  bsc_pkg::in_item_t  in_i,
  output logic               empty,
  input  logic               pop,
  output bsc_pkg::out_item_t out_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [1:0]         cfg_data_i
);

  logic                direction_q, direction_d;
  logic [1:0]          alphabet_q, alphabet_d;
  logic                cfg_we;
  bsc_pkg::front_cfg_t front_cfg;
  logic                accept;
  logic                job_we;
  bsc_pkg::job_t       job_wr, job_rd;
  logic                job_valid, job_rd_en;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign accept      = push && !full;

  always_comb begin
    direction_d = direction_q;
    alphabet_d  = alphabet_q;
    if (cfg_we) begin
      unique case (cfg_index_i)
        bsc_pkg::CFG_DIRECTION: direction_d = cfg_data_i[0];
        bsc_pkg::CFG_ALPHABET:  alphabet_d  = cfg_data_i;
        default:                direction_d = direction_q;
      endcase
    end
    front_cfg.direction = direction_q;
    front_cfg.clear     = cfg_we && (cfg_index_i == bsc_pkg::CFG_DIRECTION);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direction_q <= bsc_pkg::DIR_ENCODE;
      alphabet_q  <= bsc_pkg::ALPH_PLUS;
    end else begin
      direction_q <= direction_d;
      alphabet_q  <= alphabet_d;
    end
  end

  bsc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (front_cfg),
    .accept_i (accept),
    .item_i   (in_i),
    .job_we_o (job_we),
    .job_o    (job_wr)
  );

  bsc_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (job_we),
    .wr_data_i  (job_wr),
    .full_o     (full),
    .rd_en_i    (job_rd_en),
    .rd_data_o  (job_rd),
    .rd_valid_o (job_valid)
  );

  bsc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .alphabet_i (alphabet_q),
    .rd_valid_i (job_valid),
    .rd_data_i  (job_rd),
    .rd_en_o    (job_rd_en),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_o      (out_o)
  );

endmodule

/* hdl/bsc_front.sv */
module bsc_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bsc_pkg::front_cfg_t  cfg_i,
  input  logic                 accept_i,
  input  bsc_pkg::in_item_t    item_i,
  output logic                 job_we_o,
  output bsc_pkg::job_t        job_o
);

  logic [1:0]  pos_q, pos_d;
  logic [23:0] held_q, held_d;
  logic [1:0]  pad_q, pad_d;
  logic        discard_q, discard_d;

  logic [23:0]   held_sh;
  bsc_pkg::dec_t dc;
  logic          short_grp;
  logic [1:0]    pads_n;
  logic [23:0]   held_n;

  always_comb begin
    pos_d     = pos_q;
    held_d    = held_q;
    pad_d     = pad_q;
    discard_d = discard_q;
    job_we_o  = 1'b0;
    job_o     = '0;
    held_sh   = {held_q[15:0], item_i.in_byte};
    dc        = bsc_pkg::dec_char(item_i.in_byte);
    short_grp = item_i.in_last && (pos_q != 2'd3);
    pads_n    = pad_q | {(pos_q == 2'd3) && dc.pad, (pos_q == 2'd2) && dc.pad};
    held_n    = {held_q[17:0], dc.v};

    if (cfg_i.clear) begin
      pos_d     = '0;
      held_d    = '0;
      pad_d     = '0;
      discard_d = 1'b0;
    end else if (accept_i) begin
      if (cfg_i.direction == bsc_pkg::DIR_ENCODE) begin
        if (pos_q[1]) begin
          job_we_o        = 1'b1;
          job_o.kind      = bsc_pkg::JOB_ENC;
          job_o.bits      = held_sh;
          job_o.final_idx = 2'd3;
          job_o.last      = item_i.in_last;
          pos_d           = '0;
          held_d          = '0;
        end else if (!item_i.in_last) begin
          pos_d  = pos_q + 2'd1;
          held_d = held_sh;
        end else begin
          // short final group: pad out to four characters
          job_we_o        = 1'b1;
          job_o.kind      = bsc_pkg::JOB_ENC;
          job_o.bits      = (pos_q == 2'd0) ? {item_i.in_byte, 16'h0000}
                                            : {held_q[7:0], item_i.in_byte, 8'h00};
          job_o.npad      = (pos_q == 2'd0) ? 2'd2 : 2'd1;
          job_o.final_idx = 2'd3;
          job_o.last      = 1'b1;
          pos_d           = '0;
          held_d          = '0;
        end
      end else begin
        if (discard_q) begin
          if (item_i.in_last) begin
            discard_d = 1'b0;
          end
        end else if (short_grp || !dc.ok) begin
          job_we_o        = 1'b1;
          job_o.kind      = bsc_pkg::JOB_ERR;
          job_o.status    = short_grp ? bsc_pkg::ST_BAD_LEN : bsc_pkg::ST_BAD_CHAR;
          job_o.last      = 1'b1;
          pos_d           = '0;
          held_d          = '0;
          pad_d           = '0;
          discard_d       = !item_i.in_last;
        end else if (pos_q != 2'd3) begin
          pos_d  = pos_q + 2'd1;
          held_d = held_n;
          pad_d  = pads_n;
        end else begin
          job_we_o        = 1'b1;
          job_o.kind      = bsc_pkg::JOB_DEC;
          job_o.bits      = held_n;
          job_o.final_idx = item_i.in_last
                          ? 2'd2 - {1'b0, pads_n[0]} - {1'b0, pads_n[1]}
                          : 2'd2;
          job_o.last      = item_i.in_last;
          pos_d           = '0;
          held_d          = '0;
          pad_d           = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      held_q    <= '0;
      pad_q     <= '0;
      discard_q <= 1'b0;
    end else begin
      pos_q     <= pos_d;
      held_q    <= held_d;
      pad_q     <= pad_d;
      discard_q <= discard_d;
    end
  end

  a_discard_at_group_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    discard_q |-> (pos_q == 2'd0 && pad_q == 2'd0))
    else $error("discard set mid-group");

endmodule

/* hdl/bsc_fifo.sv */
module bsc_fifo #(
  parameter int unsigned Depth = bsc_pkg::QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_en_i,
  input  bsc_pkg::job_t wr_data_i,
  output logic          full_o,
  input  logic          rd_en_i,
  output bsc_pkg::job_t rd_data_o,
  output logic          rd_valid_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  bsc_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  function automatic logic [PtrW-1:0] ptr_next(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign full_o     = (count_q == CntW'(Depth));
  assign rd_valid_o = (count_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_en_i ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = rd_en_i ? ptr_next(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + CntW'(wr_en_i) - CntW'(rd_en_i);
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count overflow");

endmodule

/* hdl/bsc_back.sv */
module bsc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [1:0]         alphabet_i,
  input  logic               rd_valid_i,
  input  bsc_pkg::job_t      rd_data_i,
  output logic               rd_en_o,
  output logic               empty_o,
  input  logic               pop_i,
  output bsc_pkg::out_item_t out_o
);

  logic [1:0]         idx_q, idx_d;
  logic               out_valid_q, out_valid_d;
  bsc_pkg::out_item_t out_q, out_d, res;
  logic               take;
  logic [5:0]         sextet;
  logic               is_pad;

  assign take    = rd_valid_i && (!out_valid_q || pop_i);
  assign empty_o = !out_valid_q;
  assign out_o   = out_q;

  always_comb begin
    unique case (idx_q)
      2'd0:    sextet = rd_data_i.bits[23:18];
      2'd1:    sextet = rd_data_i.bits[17:12];
      2'd2:    sextet = rd_data_i.bits[11:6];
      default: sextet = rd_data_i.bits[5:0];
    endcase
    is_pad = ((idx_q == 2'd3) && (rd_data_i.npad != 2'd0))
          || ((idx_q == 2'd2) && (rd_data_i.npad == 2'd2));

    res = '0;
    unique case (rd_data_i.kind)
      bsc_pkg::JOB_ENC: begin
        res.out_byte = is_pad ? bsc_pkg::pad_char(alphabet_i)
                              : bsc_pkg::enc_char(sextet, alphabet_i);
        res.out_last = rd_data_i.last && (idx_q == rd_data_i.final_idx);
        res.status   = bsc_pkg::ST_OK;
      end
      bsc_pkg::JOB_DEC: begin
        unique case (idx_q)
          2'd0:    res.out_byte = rd_data_i.bits[23:16];
          2'd1:    res.out_byte = rd_data_i.bits[15:8];
          default: res.out_byte = rd_data_i.bits[7:0];
        endcase
        res.out_last = rd_data_i.last && (idx_q == rd_data_i.final_idx);
        res.status   = bsc_pkg::ST_OK;
      end
      bsc_pkg::JOB_ERR: begin
        res.out_byte = 8'h00;
        res.out_last = 1'b1;
        res.status   = rd_data_i.status;
      end
      default: begin
        res = '0;
      end
    endcase
  end

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    rd_en_o     = 1'b0;
    if (take) begin
      out_d       = res;
      out_valid_d = 1'b1;
      // retire the job after its final result
      if (idx_q == rd_data_i.final_idx) begin
        rd_en_o = 1'b1;
        idx_d   = '0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_error_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status != bsc_pkg::ST_OK) |-> out_q.out_last)
    else $error("error result not marked last");

  a_idx_in_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_valid_i |-> (idx_q <= rd_data_i.final_idx))
    else $error("result index past end of job");

  a_idle_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rd_valid_i |-> (idx_q == 2'd0))
    else $error("index not reset between jobs");

endmodule

/* tb/base64_stream_codec_chk.sv */
module base64_stream_codec_chk (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic                 full_i,
  input  bsc_pkg::in_item_t    in_i,
  input  logic                 empty_i,
  input  logic                 pop_i,
  input  bsc_pkg::out_item_t   out_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic                 cfg_index_i,
  input  logic [1:0]           cfg_data_i,
  output int unsigned          fault_count_o,
  output int unsigned          owed_count_o,
  output int unsigned          ignored_count_o
);

  localparam logic [62*8-1:0] Glyphs =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789";
  localparam logic [7:0] PadEq   = 8'h3D;
  localparam logic [7:0] PadHigh = 8'h83;

  logic               dir_q;
  logic [1:0]         alph_q;
  logic [1:0]         pos_q;
  logic [23:0]        held_q;
  logic [1:0]         pads_q;
  logic               drop_q;
  bsc_pkg::out_item_t owed_out[$];

  initial begin
    fault_count_o   = 0;
    owed_count_o    = 0;
    ignored_count_o = 0;
  end

  function automatic logic [7:0] sextet_glyph(logic [5:0] v, logic [1:0] a);
    if (v < 6'd62) begin
      return Glyphs[(61 - v) * 8 +: 8];
    end
    // the spare alphabet code falls back to plus and slash
    if (v == 6'd62) begin
      return (a == bsc_pkg::ALPH_UNDERSCORE) ? "_" : (a == bsc_pkg::ALPH_HIGH) ? 8'hF8 : "+";
    end
    return (a == bsc_pkg::ALPH_UNDERSCORE) ? "@" : (a == bsc_pkg::ALPH_HIGH) ? 8'hFE : "/";
  endfunction

  function automatic logic [7:0] pad_glyph(logic [1:0] a);
    return (a == bsc_pkg::ALPH_HIGH) ? PadHigh : PadEq;
  endfunction

  // {known, value}; pads are handled by the caller
  function automatic logic [6:0] glyph_value(logic [7:0] c);
    for (int i = 0; i < 62; i++) begin
      if (Glyphs[(61 - i) * 8 +: 8] == c) begin
        return {1'b1, i[5:0]};
      end
    end
    if (c == "+" || c == "_" || c == 8'hF8) begin
      return {1'b1, 6'd62};
    end
    if (c == "/" || c == "@" || c == 8'hFE) begin
      return {1'b1, 6'd63};
    end
    return '0;
  endfunction

  task automatic report(string msg);
    fault_count_o++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  task automatic owe(logic [7:0] b, logic l, bsc_pkg::status_e s);
    bsc_pkg::out_item_t r;
    r.out_byte = b;
    r.out_last = l;
    r.status   = s;
    owed_out = {owed_out, r};
  endtask

  task automatic clear_group();
    pos_q  = '0;
    held_q = '0;
    pads_q = '0;
    drop_q = 1'b0;
  endtask

  task automatic encode_byte(logic [7:0] b, logic l);
    int unsigned n;
    logic [23:0] g;
    n = pos_q + 1;
    held_q = {held_q[15:0], b};
    if (n >= 3) begin
      owe(sextet_glyph(held_q[23:18], alph_q), 1'b0, bsc_pkg::ST_OK);
      owe(sextet_glyph(held_q[17:12], alph_q), 1'b0, bsc_pkg::ST_OK);
      owe(sextet_glyph(held_q[11:6], alph_q), 1'b0, bsc_pkg::ST_OK);
      owe(sextet_glyph(held_q[5:0], alph_q), l, bsc_pkg::ST_OK);
      clear_group();
    end else if (!l) begin
      pos_q = n[1:0];
    end else begin
      // left-align the partial group, then pad
      g = held_q << (8 * (3 - n));
      owe(sextet_glyph(g[23:18], alph_q), 1'b0, bsc_pkg::ST_OK);
      owe(sextet_glyph(g[17:12], alph_q), 1'b0, bsc_pkg::ST_OK);
      owe((n == 2) ? sextet_glyph(g[11:6], alph_q) : pad_glyph(alph_q), 1'b0,
          bsc_pkg::ST_OK);
      owe(pad_glyph(alph_q), 1'b1, bsc_pkg::ST_OK);
      clear_group();
    end
  endtask

  task automatic decode_char(logic [7:0] c, logic l);
    logic       is_pad;
    logic [6:0] dv;
    logic       short_end;
    int         cnt;
    if (drop_q) begin
      ignored_count_o++;
      if (l) clear_group();
      return;
    end
    is_pad    = (c == PadEq) || (c == PadHigh);
    dv        = is_pad ? 7'b1000000 : glyph_value(c);
    short_end = l && (pos_q != 2'd3);
    if (short_end || !dv[6]) begin
      owe(8'h00, 1'b1, short_end ? bsc_pkg::ST_BAD_LEN : bsc_pkg::ST_BAD_CHAR);
      clear_group();
      drop_q = !l;
      return;
    end
    if (is_pad && pos_q == 2'd2) pads_q[0] = 1'b1;
    if (is_pad && pos_q == 2'd3) pads_q[1] = 1'b1;
    held_q = {held_q[17:0], dv[5:0]};
    if (pos_q != 2'd3) begin
      pos_q++;
      return;
    end
    // trailing pads only trim bytes in the final group
    cnt = 3;
    if (l) cnt = 3 - pads_q[0] - pads_q[1];
    for (int n = 0; n < cnt; n++) begin
      owe(held_q[23 - 8 * n -: 8], l && (n == cnt - 1), bsc_pkg::ST_OK);
    end
    pos_q  = '0;
    held_q = '0;
    pads_q = '0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    bsc_pkg::out_item_t want;
    if (!rst_ni) begin
      dir_q  = bsc_pkg::DIR_ENCODE;
      alph_q = bsc_pkg::ALPH_PLUS;
      clear_group();
      owed_out.delete();
    end else begin
      if (pop_i && !empty_i) begin
        if (owed_out.size() == 0) begin
          report($sformatf("unexpected result byte %02h last %0b status %0d",
                           out_i.out_byte, out_i.out_last, out_i.status));
        end else begin
          want = owed_out.pop_front();
          if (out_i.out_byte !== want.out_byte)
            report($sformatf("out_byte %02h, want %02h", out_i.out_byte, want.out_byte));
          if (out_i.out_last !== want.out_last)
            report($sformatf("out_last %0b, want %0b", out_i.out_last, want.out_last));
          if (out_i.status !== want.status)
            report($sformatf("status %0d, want %0d", out_i.status, want.status));
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == bsc_pkg::CFG_DIRECTION) begin
          dir_q = cfg_data_i[0];
          clear_group();
        end else begin
          alph_q = cfg_data_i;
        end
      end
      if (push_i && !full_i) begin
        if (dir_q == bsc_pkg::DIR_DECODE) decode_char(in_i.in_byte, in_i.in_last);
        else encode_byte(in_i.in_byte, in_i.in_last);
      end
    end
    owed_count_o = owed_out.size();
  end

endmodule

/* tb/base64_stream_codec_tb.sv */
module base64_stream_codec_tb;

  localparam logic [1:0]  ALPH_SPARE   = 2'd3;
  localparam logic [7:0]  PadEq        = 8'h3D;
  localparam logic [7:0]  PadHigh      = 8'h83;
  localparam int unsigned ItemTarget   = 230;
  localparam int unsigned StallLimit   = 500;
  localparam int unsigned SettleCycles = 12;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               push;
  logic               full;
  bsc_pkg::in_item_t  in_i;
  logic               empty;
  logic               pop;
  bsc_pkg::out_item_t out_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic               cfg_index_i;
  logic [1:0]         cfg_data_i;

  int unsigned fault_count, owed_count, ignored_count;
  int unsigned items_sent, results_taken, cfg_writes, streams, quiet_cycles;
  logic        calm;
  logic        decoding;

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  base64_stream_codec dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_i        (in_i),
    .empty       (empty),
    .pop         (pop),
    .out_o       (out_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  base64_stream_codec_chk u_chk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .full_i          (full),
    .in_i            (in_i),
    .empty_i         (empty),
    .pop_i           (pop),
    .out_i           (out_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .fault_count_o   (fault_count),
    .owed_count_o    (owed_count),
    .ignored_count_o (ignored_count)
  );

  // watchdog: cycles in which no request of any kind is taken
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) results_taken++;
      if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("timeout after %0d idle cycles", quiet_cycles);
        $display("base64_stream_codec_tb: done, errors");
        $finish;
      end
    end
  end

  // result side: random stall before each pop, none while calm
  initial begin : drain_results
    int unsigned gap;
    pop = 1'b0;
    @(negedge clk_i);
    while (rst_ni !== 1'b1) @(negedge clk_i);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      pop <= 1'b1;
      forever begin
        @(posedge clk_i);
        if (!empty) break;
      end
      @(negedge clk_i);
    end
  end

  task automatic send_item(logic [7:0] b, logic l);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    @(negedge clk_i);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push <= 1'b1;
    in_i <= {b, l};
    forever begin
      @(posedge clk_i);
      if (!full) break;
    end
    items_sent++;
  endtask

  task automatic hold_sender();
    @(negedge clk_i);
    push <= 1'b0;
  endtask

  // hold input until every owed result is out, then let the pipe settle
  task automatic quiesce();
    hold_sender();
    while (owed_count != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [1:0] val);
    quiesce();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    cfg_writes++;
    if (idx == bsc_pkg::CFG_DIRECTION) decoding = (val[0] == bsc_pkg::DIR_DECODE);
  endtask

  function automatic logic [7:0] any_glyph();
    int unsigned k;
    k = $urandom_range(0, 67);
    if (k < 26) return 8'(8'h41 + k);
    if (k < 52) return 8'(8'h61 + k - 26);
    if (k < 62) return 8'(8'h30 + k - 52);
    case (k - 62)
      0:       return "+";
      1:       return "/";
      2:       return "_";
      3:       return "@";
      4:       return 8'hF8;
      default: return 8'hFE;
    endcase
  endfunction

  function automatic logic [7:0] any_pad();
    return $urandom_range(0, 1) ? PadEq : PadHigh;
  endfunction

  task automatic send_bytes(int unsigned len, logic close);
    for (int unsigned i = 0; i < len; i++) begin
      send_item(8'($urandom_range(0, 255)), close && (i == len - 1));
    end
    streams++;
  endtask

  // mostly clean groups; some short, some with a stray byte or an inner pad
  task automatic send_glyph_stream();
    int unsigned groups, total, npad, kind, odd_at;
    logic [7:0]  c;
    groups = $urandom_range(1, 3);
    total  = 4 * groups;
    npad   = $urandom_range(0, 2);
    kind   = $urandom_range(0, 9);
    if (kind == 0) total = total - $urandom_range(1, 3);
    odd_at = (kind == 1 || kind == 2) ? $urandom_range(0, total - 1) : total;
    for (int unsigned i = 0; i < total; i++) begin
      if (i == odd_at) c = (kind == 1) ? 8'($urandom_range(0, 255)) : any_pad();
      else if (kind != 0 && i >= total - npad) c = any_pad();
      else c = any_glyph();
      send_item(c, i == total - 1);
    end
    streams++;
  endtask

  initial begin : stimulus
    logic [1:0]  val;
    rst_ni        = 1'b0;
    push          = 1'b0;
    in_i          = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = bsc_pkg::CFG_DIRECTION;
    cfg_data_i    = '0;
    calm          = 1'b0;
    decoding      = 1'b0;
    items_sent    = 0;
    results_taken = 0;
    cfg_writes    = 0;
    streams       = 0;
    quiet_cycles  = 0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // encode: sextets 62 and 63, one and two byte tails
    send_item(8'hFB, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'hBF, 1'b1);
    send_item(8'h00, 1'b1);
    send_item(8'hFF, 1'b0);
    send_item(8'hFE, 1'b1);
    write_reg(bsc_pkg::CFG_ALPHABET, bsc_pkg::ALPH_HIGH);
    send_item(8'hFF, 1'b1);
    send_item(8'hFB, 1'b0);
    send_item(8'hEF, 1'b1);
    // switch the alphabet with a group half filled
    send_item(8'hFB, 1'b0);
    send_item(8'hFF, 1'b0);
    write_reg(bsc_pkg::CFG_ALPHABET, bsc_pkg::ALPH_UNDERSCORE);
    send_item(8'hBF, 1'b1);
    write_reg(bsc_pkg::CFG_ALPHABET, ALPH_SPARE);
    send_item(8'hFB, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'hBF, 1'b1);

    // decode: high alphabet with one pad, pads leading and trailing,
    // bad character then drop, short stream ending on a bad character
    write_reg(bsc_pkg::CFG_DIRECTION, {1'b0, bsc_pkg::DIR_DECODE});
    send_item(8'hF8, 1'b0);
    send_item("z", 1'b0);
    send_item("0", 1'b0);
    send_item(PadHigh, 1'b1);
    send_item(PadEq, 1'b0);
    send_item("A", 1'b0);
    send_item(PadEq, 1'b0);
    send_item(PadEq, 1'b1);
    send_item("!", 1'b0);
    send_item("A", 1'b1);
    send_item("A", 1'b0);
    send_item("*", 1'b1);
    streams += 10;

    while (items_sent < ItemTarget) begin
      calm = ($urandom_range(0, 3) == 0);
      val  = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 4))
        0:       write_reg(bsc_pkg::CFG_DIRECTION, val);
        1:       write_reg(bsc_pkg::CFG_ALPHABET, val);
        2:       quiesce();
        default: ;
      endcase
      repeat ($urandom_range(1, 4)) begin
        if (decoding) begin
          if ($urandom_range(0, 7) == 0) begin
            send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
          end else begin
            send_glyph_stream();
          end
        end else begin
          send_bytes($urandom_range(1, 10), $urandom_range(0, 5) != 0);
        end
      end
    end

    calm = 1'b0;
    hold_sender();
    while (owed_count != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);

    $display("covered %0d requests over %0d streams, %0d results, %0d register writes",
             items_sent, streams, results_taken, cfg_writes);
    $display("%0d decode requests dropped after faults, %0d mismatches",
             ignored_count, fault_count);
    if (fault_count == 0) begin
      $display("base64_stream_codec_tb: done, clean");
    end else begin
      $display("base64_stream_codec_tb: done, errors");
    end
    $finish;
  end

endmodule
